### rtl/bitmap_text_rasterizer_defines.svh
// Assertion macros used by the rasterizer datapath.
`ifndef BITMAP_TEXT_RASTERIZER_DEFINES_SVH
`define BITMAP_TEXT_RASTERIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk and silent while rst_n is low.
`define BTR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and silent while rst_n is low.
`define BTR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/btr_pkg.sv
// Shared constants, types and codes of the bitmap text rasterizer.
package btr_pkg;

    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 2'd2;

    // Character codes.
    localparam logic [CHAR_W-1:0] NUL_CODE        = 8'h00;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'h0A;
    localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'h7E;

    localparam int DEF_GLYPH_COUNT = 95;
    localparam int DEF_GLYPH_ROWS  = 11;
    localparam int GLYPH_COLUMNS   = 8;
    localparam int COL_W           = $clog2(GLYPH_COLUMNS);
    localparam int LINE_PITCH      = 12;
    localparam int ROM_SIZE        = 1045;
    localparam int ROM_AW          = $clog2(ROM_SIZE);
    localparam int MAX_WRITES      = 64;
    localparam int CNT_W           = $clog2(MAX_WRITES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH
    } btr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic load_row;
        logic first_row;
        logic step;
        logic write_pixel;
        logic flush;
        logic advance_cursor;
    } btr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic glyph_char;
        logic bit_set;
        logic row_end;
        logic last_row;
        logic count_last;
        logic pend_valid;
        logic slot_free;
    } btr_stat_t;

endpackage

### rtl/btr_char_if.sv
// Character input channel: valid/ready handshake with the text byte and begin flag.
interface btr_char_if;
    import btr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              begin_text;

    modport source (output valid, output character, output begin_text, input ready);
    modport sink   (input valid, input character, input begin_text, output ready);
endinterface

### rtl/btr_pix_if.sv
// Pixel write output channel: valid/ready handshake with coordinates and colour.
interface btr_pix_if;
    import btr_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                    input last_pixel, output ready);
endinterface

### rtl/btr_ctrl.sv
// Controller state machine of the rasterizer: sequences fetch, row scan and flush.
module btr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  btr_pkg::btr_stat_t stat,
    output logic              in_ready,
    output btr_pkg::btr_cmd_t  cmd
);
    import btr_pkg::*;

    btr_state_t state_reg;
    btr_state_t state_next;
    logic       stall;
    logic       scan_final;

    // A set bit cannot retire the pending pixel while the output register is full.
    assign stall      = stat.bit_set && stat.pend_valid && !stat.slot_free;
    assign scan_final = (stat.row_end && stat.last_row) || (stat.bit_set && stat.count_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.glyph_char)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!stall && scan_final)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid || stat.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_item = in_valid;
            end
            ST_FETCH:
            begin
            end
            ST_LOAD:
            begin
                cmd.load_row  = 1'b1;
                cmd.first_row = 1'b1;
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    cmd.write_pixel = stat.bit_set;
                    if (!scan_final)
                    begin
                        if (stat.row_end)
                        begin
                            cmd.load_row = 1'b1;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    cmd.advance_cursor = 1'b1;
                end
                else if (stat.slot_free)
                begin
                    cmd.flush          = 1'b1;
                    cmd.advance_cursor = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/btr_dp.sv
// Datapath of the rasterizer: registers, cursor, font ROM, row scanner and output stage.
module btr_dp #(
    parameter int GLYPH_COUNT = btr_pkg::DEF_GLYPH_COUNT,
    parameter int GLYPH_ROWS  = btr_pkg::DEF_GLYPH_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [btr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [btr_pkg::CHAR_W-1:0]     character,
    input  logic                          begin_text,
    input  logic                          out_ready,
    input  btr_pkg::btr_cmd_t              cmd,
    output btr_pkg::btr_stat_t             stat,
    output logic                          out_valid,
    output logic [btr_pkg::COORD_W-1:0]    pixel_x,
    output logic [btr_pkg::COORD_W-1:0]    pixel_y,
    output logic [btr_pkg::COLOR_W-1:0]    pixel_color,
    output logic                          last_pixel
);
    import btr_pkg::*;

`include "bitmap_text_rasterizer_defines.svh"

    localparam int ADDR_W = $clog2(GLYPH_COUNT * GLYPH_ROWS + 1);
    localparam int ROW_W  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

    // Font table, glyph 0x20 first, eleven bytes per glyph, byte 0 in the top bits.
    localparam logic [ROM_SIZE*8-1:0] FONT_BITS = {
        88'h00_00_00_00_00_00_00_00_00_00_00,
        88'h10_10_10_10_10_10_10_00_10_00_00,
        88'h28_28_00_00_00_00_00_00_00_00_00,
        88'h14_14_7E_28_28_28_FC_50_50_00_00,
        88'h10_38_44_40_38_04_44_38_10_00_00,
        88'h40_A2_44_08_10_20_44_8A_04_00_00,
        88'h30_40_40_20_60_92_94_88_76_00_00,
        88'h10_10_00_00_00_00_00_00_00_00_00,
        88'h08_10_10_20_20_20_20_20_10_10_08,
        88'h20_10_10_08_08_08_08_08_10_10_20,
        88'h00_00_6C_38_FE_38_6C_00_00_00_00,
        88'h00_10_10_10_FE_10_10_10_00_00_00,
        88'h00_00_00_00_00_00_00_00_10_20_00,
        88'h00_00_00_00_FE_00_00_00_00_00_00,
        88'h00_00_00_00_00_00_00_00_10_00_00,
        88'h02_04_08_10_20_40_80_00_00_00_00,
        88'h38_44_44_44_44_44_44_44_38_00_00,
        88'h10_70_10_10_10_10_10_10_7C_00_00,
        88'h38_44_04_04_08_10_20_40_7C_00_00,
        88'h38_44_04_04_18_04_04_44_38_00_00,
        88'h08_18_18_28_28_48_7C_08_1C_00_00,
        88'h7C_40_40_40_78_04_04_44_38_00_00,
        88'h18_20_40_40_78_44_44_44_38_00_00,
        88'h7C_44_04_08_08_10_10_20_20_00_00,
        88'h38_44_44_44_38_44_44_44_38_00_00,
        88'h38_44_44_44_3C_04_04_08_30_00_00,
        88'h00_00_10_00_00_00_10_00_00_00_00,
        88'h00_00_10_00_00_00_10_20_00_00_00,
        88'h00_04_08_10_20_10_08_04_00_00_00,
        88'h00_00_00_7C_00_7C_00_00_00_00_00,
        88'h00_20_10_08_04_08_10_20_00_00_00,
        88'h38_44_04_04_08_10_10_00_10_00_00,
        88'h3C_42_9A_AA_AA_AA_9C_40_38_00_00,
        88'h30_10_10_28_28_44_7C_44_EE_00_00,
        88'hFC_42_42_42_7C_42_42_42_FC_00_00,
        88'h3C_42_80_80_80_80_80_42_3C_00_00,
        88'hF8_44_42_42_42_42_42_44_F8_00_00,
        88'hFE_42_40_48_78_48_40_42_FE_00_00,
        88'hFE_42_40_48_78_48_40_40_F0_00_00,
        88'h3C_42_80_80_80_8E_82_42_3C_00_00,
        88'hEE_44_44_44_7C_44_44_44_EE_00_00,
        88'h7C_10_10_10_10_10_10_10_7C_00_00,
        88'h1E_04_04_04_04_04_44_44_38_00_00,
        88'hE6_44_48_48_50_70_48_44_E6_00_00,
        88'hF8_20_20_20_20_20_20_22_FE_00_00,
        88'hC6_44_6C_6C_54_54_44_44_EE_00_00,
        88'hCE_44_64_64_54_4C_4C_44_E4_00_00,
        88'h38_44_82_82_82_82_82_44_38_00_00,
        88'hFC_42_42_42_7C_40_40_40_F0_00_00,
        88'h38_44_82_82_82_82_82_44_38_36_00,
        88'hFC_42_42_42_7C_48_48_44_E6_00_00,
        88'h7C_82_80_80_7C_02_02_82_7C_00_00,
        88'hFE_92_10_10_10_10_10_10_38_00_00,
        88'hEE_44_44_44_44_44_44_44_38_00_00,
        88'hEE_44_44_44_28_28_28_10_10_00_00,
        88'hEE_44_44_44_54_54_54_28_28_00_00,
        88'hEE_44_28_28_10_28_28_44_EE_00_00,
        88'hEE_44_44_28_28_10_10_10_38_00_00,
        88'hFE_84_08_08_10_20_20_42_FE_00_00,
        88'h38_20_20_20_20_20_20_20_38_00_00,
        88'h80_40_20_10_08_04_02_00_00_00_00,
        88'h1C_04_04_04_04_04_04_04_1C_00_00,
        88'h10_28_44_00_00_00_00_00_00_00_00,
        88'h00_00_00_00_00_00_00_00_FE_00_00,
        88'h20_10_00_00_00_00_00_00_00_00_00,
        88'h00_00_00_78_04_7C_84_84_7A_00_00,
        88'hC0_40_40_7C_42_42_42_42_FC_00_00,
        88'h00_00_00_7C_82_80_80_82_7C_00_00,
        88'h0C_04_04_7C_84_84_84_84_7E_00_00,
        88'h00_00_00_7C_82_FE_80_82_7C_00_00,
        88'h30_40_40_F0_40_40_40_40_F0_00_00,
        88'h00_00_00_7E_84_84_84_7C_04_04_78,
        88'hC0_40_40_58_64_44_44_44_EE_00_00,
        88'h08_00_00_38_08_08_08_08_3E_00_00,
        88'h08_00_00_78_08_08_08_08_08_08_70,
        88'hC0_40_40_4C_48_50_70_48_C6_00_00,
        88'h30_10_10_10_10_10_10_10_7C_00_00,
        88'h00_00_00_E8_54_54_54_54_D6_00_00,
        88'h00_00_00_D8_64_44_44_44_EE_00_00,
        88'h00_00_00_7C_82_82_82_82_7C_00_00,
        88'h00_00_00_FC_42_42_42_42_7C_40_E0,
        88'h00_00_00_7E_84_84_84_7C_04_0E_00,
        88'h00_00_00_EC_32_20_20_20_F8_00_00,
        88'h00_00_00_7C_82_70_0C_82_7C_00_00,
        88'h00_20_20_78_20_20_20_24_18_00_00,
        88'h00_00_00_CC_44_44_44_4C_36_00_00,
        88'h00_00_00_EE_44_44_28_28_10_00_00,
        88'h00_00_00_EE_44_54_54_28_28_00_00,
        88'h00_00_00_EE_44_38_38_44_EE_00_00,
        88'h00_00_00_EE_44_44_28_28_10_10_60,
        88'h00_00_00_FC_88_10_20_44_FC_00_00,
        88'h0C_10_10_10_10_60_10_10_10_10_0C,
        88'h10_10_10_10_10_10_10_10_10_10_10,
        88'h60_10_10_10_10_0C_10_10_10_10_60,
        88'h00_00_62_92_8C_00_00_00_00_00_00
    };

    logic [COORD_W-1:0] origin_x_reg,  origin_x_next;
    logic [COORD_W-1:0] origin_y_reg,  origin_y_next;
    logic [COLOR_W-1:0] text_color_reg, text_color_next;
    logic [COORD_W-1:0] cursor_x_reg,  cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg,  cursor_y_next;

    logic [ADDR_W-1:0]  rom_addr_reg,  rom_addr_next;
    logic [ROM_AW-1:0]  rom_idx;
    logic [7:0]         rom_q_reg;
    logic [7:0]         row_bits_reg,  row_bits_next;
    logic [COL_W-1:0]   col_reg,       col_next;
    logic [ROW_W-1:0]   row_reg,       row_next;
    logic [CNT_W-1:0]   wr_count_reg,  wr_count_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [COORD_W-1:0] pend_x_reg,    pend_x_next;
    logic [COORD_W-1:0] pend_y_reg,    pend_y_next;

    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_x_reg,     out_x_next;
    logic [COORD_W-1:0] out_y_reg,     out_y_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;
    logic               out_last_reg,  out_last_next;

    logic [COORD_W-1:0] eff_x;
    logic [COORD_W-1:0] eff_y;
    logic [CHAR_W-1:0]  glyph_idx;
    logic               is_glyph;
    logic [ADDR_W-1:0]  glyph_base;
    logic               out_load;

    // Item decode.
    assign eff_x      = begin_text ? origin_x_reg : cursor_x_reg;
    assign eff_y      = begin_text ? origin_y_reg : cursor_y_reg;
    assign glyph_idx  = character - FIRST_PRINTABLE;
    assign is_glyph   = (character >= FIRST_PRINTABLE) && (character <= LAST_PRINTABLE)
                        && (int'(glyph_idx) < GLYPH_COUNT);
    assign glyph_base = ADDR_W'(int'(glyph_idx) * GLYPH_ROWS);
    assign rom_idx    = ROM_AW'(rom_addr_reg);

    assign out_load = (cmd.write_pixel && pend_valid_reg) || cmd.flush;

    always_comb
    begin
        stat.glyph_char = is_glyph;
        stat.bit_set    = row_bits_reg[7];
        stat.row_end    = (col_reg == COL_W'(GLYPH_COLUMNS - 1));
        stat.last_row   = (row_reg == ROW_W'(GLYPH_ROWS - 1));
        stat.count_last = (wr_count_reg == CNT_W'(MAX_WRITES - 1));
        stat.pend_valid = pend_valid_reg;
        stat.slot_free  = !out_valid_reg || out_ready;
    end

    // Configuration registers.
    always_comb
    begin
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        text_color_next = text_color_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:   origin_x_next   = cfg_data;
                REG_ORIGIN_Y:   origin_y_next   = cfg_data;
                REG_TEXT_COLOR: text_color_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Cursor.
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cmd.take_item)
        begin
            priority if (character == NUL_CODE)
            begin
                cursor_x_next = eff_x;
                cursor_y_next = eff_y;
            end
            else if (character == NEWLINE_CODE)
            begin
                cursor_x_next = origin_x_reg;
                cursor_y_next = eff_y + COORD_W'(LINE_PITCH);
            end
            else if (is_glyph)
            begin
                cursor_x_next = eff_x;
                cursor_y_next = eff_y;
            end
            else
            begin
                cursor_x_next = eff_x + COORD_W'(GLYPH_COLUMNS);
                cursor_y_next = eff_y;
            end
        end
        else if (cmd.advance_cursor)
        begin
            cursor_x_next = cursor_x_reg + COORD_W'(GLYPH_COLUMNS);
        end
    end

    // Row scanner and pending pixel.
    always_comb
    begin
        rom_addr_next   = rom_addr_reg;
        row_bits_next   = row_bits_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        wr_count_next   = wr_count_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;

        if (cmd.take_item)
        begin
            rom_addr_next   = glyph_base;
            wr_count_next   = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.load_row)
        begin
            row_bits_next = rom_q_reg;
            rom_addr_next = rom_addr_reg + ADDR_W'(1);
            col_next      = '0;
            row_next      = cmd.first_row ? '0 : row_reg + ROW_W'(1);
        end
        else if (cmd.step)
        begin
            row_bits_next = {row_bits_reg[6:0], 1'b0};
            col_next      = col_reg + COL_W'(1);
        end
        if (cmd.write_pixel)
        begin
            pend_valid_next = 1'b1;
            pend_x_next     = cursor_x_reg + COORD_W'(col_reg);
            pend_y_next     = cursor_y_reg + COORD_W'(row_reg);
            wr_count_next   = wr_count_reg + CNT_W'(1);
        end
        else if (cmd.flush)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // Output register.
    always_comb
    begin
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_x_next     = pend_x_reg;
            out_y_next     = pend_y_reg;
            out_color_next = text_color_reg;
            out_last_next  = cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            text_color_reg <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            wr_count_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            text_color_reg <= text_color_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            wr_count_reg   <= wr_count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Font ROM read with registered data; addresses past the table read as blank.
    always_ff @(posedge clk)
    begin
        if (32'(rom_addr_reg) < ROM_SIZE)
        begin
            rom_q_reg <= FONT_BITS[(ROM_SIZE - 1 - int'(rom_idx)) * 8 +: 8];
        end
        else
        begin
            rom_q_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        rom_addr_reg  <= rom_addr_next;
        row_bits_reg  <= row_bits_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign last_pixel  = out_last_reg;

    `BTR_ASSERT_IMP(a_write_count_bound, 1'b1, wr_count_reg <= CNT_W'(MAX_WRITES), "pixel write count ran past its limit")
    `BTR_ASSERT_IMP(a_row_bound, 1'b1, row_reg <= ROW_W'(GLYPH_ROWS - 1), "row counter left the glyph cell")
    `BTR_ASSERT_IMP(a_pend_room, cmd.write_pixel && pend_valid_reg, !out_valid_reg || out_ready, "pending pixel moved into a full output register")
    `BTR_ASSERT_NEXT(a_flush_marks_last, cmd.flush, out_valid_reg && out_last_reg, "flushed pixel not shown as the last one")

endmodule

### rtl/bitmap_text_rasterizer.sv
// Top level of the bitmap text rasterizer: channels, configuration port and the two halves.
//
// The rasterizer takes one text character per item and turns it into pixel writes
// in an 8-column, GLYPH_ROWS-row font cell at a text cursor that it keeps itself.
// A set begin_text flag first puts the cursor back at (origin_x, origin_y). A newline
// returns x to origin_x and steps y down twelve rows; a zero character only applies
// the begin flag; bytes outside the printable range are drawn blank but still move
// the cursor on by eight columns. These items finish in the cycle they are accepted.
// A printable character is scanned one cell position per cycle unless the pixel
// output holds it off, top row first and leftmost column first. The character is
// accepted, the font ROM is read, the first row is loaded, the cells are scanned
// and the final pixel is flushed, in that order. A set bit or the final flush that
// finds both the pending pixel and the output register still full waits until the
// output register is free. Each set bit, up to the write limit, gives one item on
// the pixel channel in text_color, and the final one of a character carries
// last_pixel; a blank glyph gives no item at all. At most 64 writes are made per
// character. Coordinates wrap at 16 bits. The next character is accepted only once
// the previous one has been fully scanned, although its last pixel may still be
// waiting in the output register. Configuration registers are written through a
// plain write port (index 0 origin_x, 1 origin_y, 2 text_color; other indexes are
// ignored) and should only be changed while no character is in progress.
module bitmap_text_rasterizer #(
    parameter int GLYPH_COUNT = btr_pkg::DEF_GLYPH_COUNT,
    parameter int GLYPH_ROWS  = btr_pkg::DEF_GLYPH_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [btr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0] cfg_data,
    btr_char_if.sink                      chars,
    btr_pix_if.source                     pixels
);
    import btr_pkg::*;

    // Command and status bundles between the sequencer and the datapath.
    btr_cmd_t  cmd;
    btr_stat_t stat;

    // The controller owns the input handshake: a character is taken only when the
    // previous one has been scanned to the end.
    btr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .stat     (stat),
        .in_ready (chars.ready),
        .cmd      (cmd)
    );

    // The datapath holds the registers, the cursor, the font ROM, the row scanner
    // with its one-pixel lookahead (needed to mark the last write) and the output
    // register that drives the pixel channel.
    btr_dp #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .character   (chars.character),
        .begin_text  (chars.begin_text),
        .out_ready   (pixels.ready),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (pixels.valid),
        .pixel_x     (pixels.pixel_x),
        .pixel_y     (pixels.pixel_y),
        .pixel_color (pixels.pixel_color),
        .last_pixel  (pixels.last_pixel)
    );

endmodule
